/* rtl/orb_pkg.sv */
// Package for the overwriting ring buffer: sizes, command codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
package orb_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 64;
    localparam int CMD_W     = 2;
    localparam int CNT_W     = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LIST   = 2'd2
    } t_cmd;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

    typedef struct packed {
        logic append;
        logic remove;
        logic list_start;
        logic read;
    } t_dp_cmd;

    typedef struct packed {
        logic nonempty;
        logic rd_ready;
        logic rd_last;
    } t_dp_sts;

endpackage

/* rtl/orb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module orb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/orb_ctrl.sv */
// Controller of the overwriting ring buffer: idle/list state machine that
// issues datapath commands. Depends on orb_pkg.
module orb_ctrl
    import orb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_command,
    input  t_dp_sts          i_sts,
    output t_dp_cmd          o_cmd,
    output logic             o_in_stall
);

    t_state r_state;
    t_state n_state;
    t_cmd   cmd_code;

    assign cmd_code = t_cmd'(i_command);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && cmd_code == CMD_LIST && i_sts.nonempty) begin
                    n_state = S_LIST;
                end
            end
            S_LIST: begin
                if (i_sts.rd_ready && i_sts.rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (cmd_code)
                        CMD_APPEND: o_cmd.append     = 1'b1;
                        CMD_REMOVE: o_cmd.remove     = 1'b1;
                        CMD_LIST:   o_cmd.list_start = i_sts.nonempty;
                        default:    o_cmd            = '0;
                    endcase
                end
            end
            S_LIST: begin
                o_in_stall = 1'b1;
                o_cmd.read = i_sts.rd_ready;
            end
            default: o_in_stall = 1'b0;
        endcase
    end

endmodule

/* rtl/orb_dp.sv */
// Datapath of the overwriting ring buffer: pointers, occupancy, capacity,
// entry store and the two-stage list output pipeline. Depends on orb_pkg, orb_ram.
module orb_dp
    import orb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [WORD_W-1:0] i_item_word,
    input  logic [CNT_W-1:0]  i_remove_count,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WORD_W-1:0] o_item_out,
    output logic              o_is_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    function automatic logic [SW-1:0] wrap(input logic [SW-1:0] a, input logic [SW-1:0] c);
        return (a >= c) ? a - c : a;
    endfunction

    logic [CW-1:0]     r_cap;
    logic [AW-1:0]     r_oldest;
    logic [CW-1:0]     r_occ;
    logic [AW-1:0]     r_rd_pos;
    logic [CW-1:0]     r_left;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_data;
    logic              r_out_last;

    logic [SW-1:0]     cap_x;
    logic [SW-1:0]     wr_pos;
    logic [SW-1:0]     old_inc;
    logic [SW-1:0]     old_rem;
    logic [SW-1:0]     rd_inc;
    logic [CW-1:0]     rem_cnt;
    logic [CNT_W-1:0]  cfg_sat;
    logic [WORD_W-1:0] ram_rdata;
    logic              out_take;
    logic              s1_move;

    assign cap_x   = SW'(r_cap);
    assign wr_pos  = wrap(SW'(r_oldest) + SW'(r_occ), cap_x);
    assign old_inc = wrap(SW'(r_oldest) + SW'(1), cap_x);
    assign rem_cnt = (i_remove_count > CNT_W'(r_occ)) ? r_occ : CW'(i_remove_count);
    assign old_rem = wrap(SW'(r_oldest) + SW'(rem_cnt), cap_x);
    assign rd_inc  = wrap(SW'(r_rd_pos) + SW'(1), cap_x);

    always_comb begin
        cfg_sat = i_cfg_wdata;
        if (i_cfg_wdata == '0) begin
            cfg_sat = CNT_W'(1);
        end else if (i_cfg_wdata > CNT_W'(DEPTH)) begin
            cfg_sat = CNT_W'(DEPTH);
        end
    end

    assign out_take = !r_out_vld || !i_out_stall;
    assign s1_move  = !r_rd_vld || out_take;

    assign o_sts.nonempty = (r_occ != '0);
    assign o_sts.rd_ready = s1_move;
    assign o_sts.rd_last  = (r_left == CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CW'(DEPTH);
            r_oldest <= '0;
            r_occ    <= '0;
            r_rd_pos <= '0;
            r_left   <= '0;
        end else if (i_cfg_we) begin
            r_cap    <= CW'(cfg_sat);
            r_oldest <= '0;
            r_occ    <= '0;
        end else begin
            if (i_cmd.append) begin
                if (r_occ >= r_cap) begin
                    r_occ    <= r_cap;
                    r_oldest <= AW'(old_inc);
                end else begin
                    r_occ <= r_occ + CW'(1);
                end
            end
            if (i_cmd.remove) begin
                r_occ <= r_occ - rem_cnt;
                if (r_occ == rem_cnt) begin
                    r_oldest <= '0;
                end else begin
                    r_oldest <= AW'(old_rem);
                end
            end
            if (i_cmd.list_start) begin
                r_rd_pos <= r_oldest;
                r_left   <= r_occ;
            end
            if (i_cmd.read) begin
                r_rd_pos <= AW'(rd_inc);
                r_left   <= r_left - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_move) begin
                r_rd_vld <= i_cmd.read;
            end
            if (out_take) begin
                r_out_vld <= r_rd_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && i_cmd.read) begin
            r_rd_last <= (r_left == CW'(1));
        end
        if (out_take && r_rd_vld) begin
            r_out_data <= ram_rdata;
            r_out_last <= r_rd_last;
        end
    end

    orb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (AW'(wr_pos)),
        .i_wdata (i_item_word),
        .i_re    (i_cmd.read),
        .i_raddr (r_rd_pos),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_vld;
    assign o_item_out  = r_out_data;
    assign o_is_last   = r_out_last;

endmodule

/* rtl/overwriting_ring_buffer_unit.sv */
// Overwriting ring buffer top level: controller plus datapath. Depends on orb_pkg, orb_ctrl, orb_dp.
// Append and remove are executed when accepted and do not hold input; the next beat is accepted in the following cycle.
// A list of a nonempty buffer holds input until its last entry is read, longer while the output stalls,
// as the store is read one entry per cycle; the first word passes the read pointer load, the
// registered RAM read and the output register; words then follow one per cycle unless stalled.
// Synchronous active-low reset: empty buffer, capacity DEPTH, store contents undefined.
module overwriting_ring_buffer_unit
    import orb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [WORD_W-1:0] i_item_word,
    input  logic [CNT_W-1:0]  i_remove_count,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [WORD_W-1:0] o_item_out,
    output logic              o_is_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    orb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    orb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_item_word    (i_item_word),
        .i_remove_count (i_remove_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_item_out     (o_item_out),
        .o_is_last      (o_is_last)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.append, dp_cmd.remove, dp_cmd.list_start, dp_cmd.read}))
        else $error("multiple datapath commands");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> dp_sts.nonempty)
        else $error("list running on empty buffer");

    a_read_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.read |-> dp_sts.rd_ready)
        else $error("read issued with full pipeline");

    a_list_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.list_start |=> o_in_stall)
        else $error("list start did not hold input");

endmodule

/* verif/tb_overwriting_ring_buffer_unit.sv */
// Self-checking testbench for overwriting_ring_buffer_unit: list output beats are checked against
// a behavioral ring model fed with the same beats, with random input gaps and random output stalls.
// Depends on orb_pkg and the RTL of overwriting_ring_buffer_unit.
module tb_overwriting_ring_buffer_unit;
    import orb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SEG_ITEMS = 27;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  count;
    } t_ring_beat;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_ring_entry;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata    = '0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_command      = CMD_APPEND;
    logic [WORD_W-1:0] i_item_word    = '0;
    logic [CNT_W-1:0]  i_remove_count = '0;
    logic              o_out_valid;
    logic              i_out_stall    = 1'b0;
    logic [WORD_W-1:0] o_item_out;
    logic              o_is_last;

    t_ring_beat  pend_beats [$];
    t_ring_entry ring_expect [$];
    t_ring_beat  cur_beat;

    logic [WORD_W-1:0] ring_mem [DEPTH_DEF];
    int unsigned ring_cap    = DEPTH_DEF;
    int unsigned ring_occ    = 0;
    int unsigned ring_oldest = 0;

    int send_idle_pct = 26;
    int recv_idle_pct = 70;
    int mismatch_cnt  = 0;

    overwriting_ring_buffer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_item_word    (i_item_word),
        .i_remove_count (i_remove_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_item_out     (o_item_out),
        .o_is_last      (o_is_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic ring_apply(input t_ring_beat b);
        int unsigned pos;
        int unsigned cnt;
        case (b.cmd)
            CMD_APPEND: begin
                pos = (ring_oldest + ring_occ) % ring_cap;
                ring_mem[pos] = b.word;
                if (ring_occ >= ring_cap) begin
                    ring_oldest = (ring_oldest + 1) % ring_cap;
                end else begin
                    ring_occ++;
                end
            end
            CMD_REMOVE: begin
                cnt = (b.count > ring_occ) ? ring_occ : b.count;
                ring_occ    = ring_occ - cnt;
                ring_oldest = (ring_oldest + cnt) % ring_cap;
                if (ring_occ == 0) begin
                    ring_oldest = 0;
                end
            end
            CMD_LIST: begin
                pos = ring_oldest;
                for (int unsigned k = 0; k < ring_occ; k++) begin
                    ring_expect.push_back('{word: ring_mem[pos], last: (k + 1 == ring_occ)});
                    pos = (pos + 1) % ring_cap;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic add_beat(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] w,
                            input logic [CNT_W-1:0] n);
        pend_beats.push_back('{cmd: c, word: w, count: n});
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic add_random_beats(input int num);
        int done;
        int r;
        done = 0;
        while (done < num) begin
            r = $urandom_range(99);
            if (r < 55) begin
                add_beat(CMD_APPEND, rand_word(), CNT_W'($urandom_range(127)));
                done++;
            end else if (r < 72) begin
                if ($urandom_range(1) != 0) begin
                    add_beat(CMD_REMOVE, rand_word(), CNT_W'($urandom_range(3)));
                end else begin
                    add_beat(CMD_REMOVE, rand_word(), CNT_W'($urandom_range(127)));
                end
                done++;
            end else if (r < 95) begin
                add_beat(CMD_LIST, rand_word(), CNT_W'($urandom_range(127)));
                done++;
            end else begin
                add_beat(CMD_UNUSED, rand_word(), CNT_W'($urandom_range(127)));
            end
        end
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (pend_beats.size() != 0 || i_in_valid || ring_expect.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        ring_cap    = (v == 0) ? 1 : ((v > DEPTH_DEF) ? DEPTH_DEF : v);
        ring_occ    = 0;
        ring_oldest = 0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                ring_apply(cur_beat);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pend_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_beat = pend_beats.pop_front();
                    i_in_valid     <= 1'b1;
                    i_command      <= cur_beat.cmd;
                    i_item_word    <= cur_beat.word;
                    i_remove_count <= cur_beat.count;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_ring_entry e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (ring_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat word=%h last=%b",
                                              o_item_out, o_is_last));
                end else begin
                    e = ring_expect.pop_front();
                    if (o_item_out !== e.word) begin
                        report_mismatch($sformatf("item_out %h, expected %h",
                                                  o_item_out, e.word));
                    end
                    if (o_is_last !== e.last) begin
                        report_mismatch($sformatf("is_last %b, expected %b",
                                                  o_is_last, e.last));
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        logic [CNT_W-1:0] seg_cap [6];
        seg_cap = '{7'd5, 7'd64, 7'd1, 7'd127, 7'd23, CNT_W'($urandom_range(2, 63))};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_beat(CMD_LIST, '0, '0);
        add_beat(CMD_REMOVE, '0, 7'd5);
        add_beat(CMD_UNUSED, '1, '1);
        add_beat(CMD_APPEND, '0, '0);
        add_beat(CMD_APPEND, '1, '1);
        add_beat(CMD_APPEND, {16{4'hA}}, '0);
        add_beat(CMD_APPEND, {16{4'h5}}, '0);
        add_beat(CMD_LIST, '0, '0);
        add_beat(CMD_REMOVE, '1, 7'd0);
        add_beat(CMD_REMOVE, '0, 7'd1);
        add_beat(CMD_LIST, '0, '0);
        add_beat(CMD_REMOVE, '0, 7'd127);
        add_beat(CMD_LIST, '0, '0);
        add_beat(CMD_APPEND, rand_word(), '0);
        add_beat(CMD_LIST, '0, '0);
        settle();
        write_capacity(7'd0);
        add_beat(CMD_APPEND, rand_word(), '0);
        add_beat(CMD_APPEND, rand_word(), '0);
        add_beat(CMD_LIST, '0, '0);
        add_beat(CMD_REMOVE, '0, 7'd1);
        add_beat(CMD_LIST, '0, '0);
        settle();
        write_capacity(7'd3);
        repeat (4) add_beat(CMD_APPEND, rand_word(), '0);
        add_beat(CMD_LIST, '0, '0);
        settle();

        for (int s = 0; s < 6; s++) begin
            if (s == 2) begin
                send_idle_pct = 70;
                recv_idle_pct = 26;
            end else if (s == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(seg_cap[s]);
            // fill past full when the capacity written is DEPTH_DEF, to force overwrites
            if (seg_cap[s] == DEPTH_DEF) begin
                repeat (DEPTH_DEF + 2) add_beat(CMD_APPEND, rand_word(), '0);
                add_beat(CMD_LIST, '0, '0);
            end
            add_random_beats(SEG_ITEMS);
            settle();
        end

        repeat (10) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/orb_pkg.sv
rtl/orb_ram.sv
rtl/orb_ctrl.sv
rtl/orb_dp.sv
rtl/overwriting_ring_buffer_unit.sv
verif/tb_overwriting_ring_buffer_unit.sv
